[hdl/ffba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    localparam int DEF_NUM_BLOCKS = 256;

    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 16;
    localparam int START_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 3;

    localparam int BLOCK_BYTES = 4;
    localparam int BLOCK_SHIFT = 2;
    localparam int ROUND_UP    = BLOCK_BYTES - 1;
    localparam int NEED_W      = BYTE_W + 1 - BLOCK_SHIFT;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_TOO_LARGE = 3'd1,
        STS_NO_MEMORY = 3'd2,
        STS_NULL_FREE = 3'd3,
        STS_OOB       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_RESULT,
        OP_SEARCH,
        OP_FREE,
        OP_CLEAR
    } op_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FILL,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_run;
        logic mark_init;
        logic free_init;
        logic clear_init;
        logic fill_run;
        logic rsp_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic found;
        logic fail;
        logic fill_done;
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/ffba_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffba_datapath #(
    parameter int NUM_BLOCKS = ffba_pkg::DEF_NUM_BLOCKS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ffba_pkg::cmd_t                 cmd,
    output ffba_pkg::dp_status_t                dp_status,
    input  wire logic [ffba_pkg::KIND_W-1:0]    kind,
    input  wire logic [ffba_pkg::BYTE_W-1:0]    byte_count,
    input  wire logic                           block_valid,
    input  wire logic [ffba_pkg::START_W-1:0]   start_block,
    input  wire logic [ffba_pkg::COUNT_W-1:0]   block_count,
    output logic      [ffba_pkg::STATUS_W-1:0]  status,
    output logic      [ffba_pkg::START_W-1:0]   run_start,
    output logic      [ffba_pkg::COUNT_W-1:0]   run_length
);
    import ffba_pkg::*;

    localparam int IW    = $clog2(NUM_BLOCKS);
    localparam int CW    = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W = (CW > COUNT_W + 1) ? CW : COUNT_W + 1;

    // used-bit map
    logic mem [NUM_BLOCKS];
    logic rd_data_reg;

    // request decode
    logic [BYTE_W:0]   need_full;
    logic [NEED_W-1:0] need_in;
    logic [CMP_W-1:0]  free_end;
    op_t               op_in;
    status_t           sts_in;
    logic [COUNT_W-1:0] len_in;

    // working registers
    op_t                op_reg;
    status_t            work_status_reg;
    logic [START_W-1:0] work_start_reg;
    logic [COUNT_W-1:0] work_len_reg;
    logic [CW-1:0]      need_reg;
    logic [IW-1:0]      fstart_reg;
    logic [CW-1:0]      fcount_reg;

    // scan
    logic [CW-1:0] scan_addr_reg, scan_addr_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic [CW-1:0] run_reg, run_next;
    logic          hit;
    logic [CW-1:0] first;

    // fill engine
    logic [IW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] wr_left_reg, wr_left_next;
    logic          wr_bit_reg, wr_bit_next;
    logic          wr_en;

    // response
    status_t            status_reg;
    logic [START_W-1:0] run_start_reg;
    logic [COUNT_W-1:0] run_length_reg;

    always_comb
    begin
        need_full = {1'b0, byte_count} + (BYTE_W + 1)'(ROUND_UP);
        need_in   = need_full[BYTE_W:BLOCK_SHIFT];
        free_end  = CMP_W'(start_block) + CMP_W'(block_count);
        op_in     = OP_RESULT;
        sts_in    = STS_OK;
        len_in    = '0;
        unique case (kind)
            KIND_ALLOC:
            begin
                if (need_in > NEED_W'(NUM_BLOCKS))
                begin
                    sts_in = STS_TOO_LARGE;
                end
                else if (need_in != '0)
                begin
                    op_in  = OP_SEARCH;
                    sts_in = STS_NO_MEMORY;
                    len_in = COUNT_W'(need_in);
                end
            end
            KIND_FREE:
            begin
                if (!block_valid)
                begin
                    sts_in = STS_NULL_FREE;
                end
                else if (free_end > CMP_W'(NUM_BLOCKS))
                begin
                    sts_in = STS_OOB;
                end
                else if (block_count != '0)
                begin
                    op_in = OP_FREE;
                end
            end
            KIND_CLEAR:
            begin
                op_in = OP_CLEAR;
            end
            default:
            begin
                op_in = OP_RESULT;
            end
        endcase
    end

    // scan: read issue stage, then check stage on the registered bit
    always_comb
    begin
        hit   = chk_valid_reg && !rd_data_reg && (CW'(run_reg + 1'b1) == need_reg);
        first = CW'(CW'(chk_idx_reg) + 1'b1 - need_reg);

        scan_addr_next = scan_addr_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = 1'b0;
        run_next       = run_reg;
        if (cmd.scan_init)
        begin
            scan_addr_next = '0;
            run_next       = '0;
        end
        else if (cmd.scan_run)
        begin
            if (scan_addr_reg < CW'(NUM_BLOCKS))
            begin
                scan_addr_next = CW'(scan_addr_reg + 1'b1);
                chk_idx_next   = scan_addr_reg[IW-1:0];
                chk_valid_next = 1'b1;
            end
            if (chk_valid_reg)
            begin
                run_next = rd_data_reg ? '0 : CW'(run_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        wr_en        = cmd.fill_run && (wr_left_reg != '0);
        wr_ptr_next  = wr_ptr_reg;
        wr_left_next = wr_left_reg;
        wr_bit_next  = wr_bit_reg;
        priority if (cmd.clear_init)
        begin
            wr_ptr_next  = '0;
            wr_left_next = CW'(NUM_BLOCKS);
            wr_bit_next  = 1'b0;
        end
        else if (cmd.free_init)
        begin
            wr_ptr_next  = fstart_reg;
            wr_left_next = fcount_reg;
            wr_bit_next  = 1'b0;
        end
        else if (cmd.mark_init)
        begin
            wr_ptr_next  = first[IW-1:0];
            wr_left_next = need_reg;
            wr_bit_next  = 1'b1;
        end
        else if (wr_en)
        begin
            wr_ptr_next  = IW'(wr_ptr_reg + 1'b1);
            wr_left_next = CW'(wr_left_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            run_reg       <= '0;
            // reset starts a clearing pass over the whole map
            wr_ptr_reg    <= '0;
            wr_left_reg   <= CW'(NUM_BLOCKS);
            wr_bit_reg    <= 1'b0;
        end
        else
        begin
            scan_addr_reg <= scan_addr_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg   <= chk_idx_next;
            run_reg       <= run_next;
            wr_ptr_reg    <= wr_ptr_next;
            wr_left_reg   <= wr_left_next;
            wr_bit_reg    <= wr_bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_bit_reg;
        end
        rd_data_reg <= mem[scan_addr_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg          <= op_in;
            work_status_reg <= sts_in;
            work_start_reg  <= '0;
            work_len_reg    <= len_in;
            need_reg        <= CW'(need_in);
            fstart_reg      <= IW'(start_block);
            fcount_reg      <= CW'(block_count);
        end
        else if (cmd.mark_init)
        begin
            work_status_reg <= STS_OK;
            work_start_reg  <= START_W'(first);
        end
        if (cmd.rsp_load)
        begin
            status_reg     <= work_status_reg;
            run_start_reg  <= work_start_reg;
            run_length_reg <= work_len_reg;
        end
    end

    assign dp_status.op        = op_reg;
    assign dp_status.found     = hit;
    assign dp_status.fail      = chk_valid_reg && !hit
                                 && (chk_idx_reg == IW'(NUM_BLOCKS - 1));
    assign dp_status.fill_done = (wr_left_reg == '0);

    assign status     = status_reg;
    assign run_start  = run_start_reg;
    assign run_length = run_length_reg;

endmodule

`default_nettype wire

[hdl/ffba_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output ffba_pkg::cmd_t             cmd,
    input  wire ffba_pkg::dp_status_t  dp_status
);
    import ffba_pkg::*;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_stall      = 1'b1;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.fill_run = 1'b1;
                if (dp_status.fill_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (dp_status.op)
                    OP_RESULT:
                    begin
                        state_next = S_RESP;
                    end
                    OP_SEARCH:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    OP_FREE:
                    begin
                        cmd.free_init = 1'b1;
                        state_next    = S_FILL;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_init = 1'b1;
                        state_next     = S_FILL;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (dp_status.found)
                begin
                    cmd.mark_init = 1'b1;
                    state_next    = S_FILL;
                end
                else if (dp_status.fail)
                begin
                    state_next = S_RESP;
                end
            end
            S_FILL:
            begin
                cmd.fill_run = 1'b1;
                if (dp_status.fill_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // hold until the output register is free or being emptied
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.rsp_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid) |=> (state_reg == S_DISPATCH))
        else $error("accepted request did not move to dispatch");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("response register overwritten while stalled");

    a_found_fail_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_status.found && dp_status.fail))
        else $error("scan reported both hit and miss");

    a_scan_single_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && dp_status.found) |=> (state_reg == S_FILL && !req_stall == 1'b0))
        else $error("run found but marking did not start");
`endif

endmodule

`default_nettype wire

[hdl/first_fit_block_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// First-fit block allocator over a used-bit map of NUM_BLOCKS 4-byte blocks,
// held in a one-bit memory with one write and one registered read port.
// After reset the block sweeps the map clear, one block per cycle, and keeps
// req_stall high until the sweep is done. One request is handled at a time.
// An allocate scans the map one bit per cycle from block 0 and then marks the
// granted run one block per cycle; a free clears its run and a clear the whole
// map, while a request that is refused before touching the map or changes
// nothing goes on to its response without writing the map.
// A finished result sits in an output register, so the next request is taken
// while it waits on rsp_stall.
module first_fit_block_allocator_top #(
    parameter int NUM_BLOCKS = ffba_pkg::DEF_NUM_BLOCKS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic [ffba_pkg::KIND_W-1:0]    kind,
    input  wire logic [ffba_pkg::BYTE_W-1:0]    byte_count,
    input  wire logic                           block_valid,
    input  wire logic [ffba_pkg::START_W-1:0]   start_block,
    input  wire logic [ffba_pkg::COUNT_W-1:0]   block_count,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output logic      [ffba_pkg::STATUS_W-1:0]  status,
    output logic      [ffba_pkg::START_W-1:0]   run_start,
    output logic      [ffba_pkg::COUNT_W-1:0]   run_length
);
    import ffba_pkg::*;

    cmd_t       cmd;
    dp_status_t dp_status;

    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

    ffba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .dp_status   (dp_status),
        .kind        (kind),
        .byte_count  (byte_count),
        .block_valid (block_valid),
        .start_block (start_block),
        .block_count (block_count),
        .status      (status),
        .run_start   (run_start),
        .run_length  (run_length)
    );

endmodule

`default_nettype wire

[tb/sv/tb_first_fit_block_allocator_top.sv]
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_top;
    import ffba_pkg::*;

    localparam int NUM_BLOCKS     = DEF_NUM_BLOCKS;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 760;
    localparam int RSP_HOLD_LONG  = 400;

    // kind 3 has no meaning; the block must answer it like a no-op
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  bytes;
        logic               valid;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
    } heap_request_t;

    typedef struct packed {
        status_t            status;
        logic [START_W-1:0] run_first;
        logic [COUNT_W-1:0] run_len;
    } alloc_outcome_t;

    typedef struct {
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
    } live_run_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                req_valid   = 1'b0;
    logic                req_stall;
    logic [KIND_W-1:0]   kind        = '0;
    logic [BYTE_W-1:0]   byte_count  = '0;
    logic                block_valid = 1'b0;
    logic [START_W-1:0]  start_block = '0;
    logic [COUNT_W-1:0]  block_count = '0;
    logic                rsp_valid;
    logic                rsp_stall   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  run_start;
    logic [COUNT_W-1:0]  run_length;

    bit [NUM_BLOCKS-1:0] used_blocks = '0;
    alloc_outcome_t      expected_outcomes[$];
    alloc_outcome_t      oldest;
    live_run_t           live_runs[$];

    int errors         = 0;
    int req_idle_pct   = 0;
    int rsp_idle_pct   = 0;
    int rsp_hold_req   = 0;
    int rsp_hold_left  = 0;
    int idle_cycles    = 0;
    int n_grants       = 0;
    int n_no_memory    = 0;
    int n_too_large    = 0;
    int n_frees        = 0;
    int n_free_rejects = 0;
    int n_clears       = 0;
    int n_unused       = 0;

    first_fit_block_allocator_top #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .kind       (kind),
        .byte_count (byte_count),
        .block_valid(block_valid),
        .start_block(start_block),
        .block_count(block_count),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .run_start  (run_start),
        .run_length (run_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(16, 80);
    endfunction

    // Applies one request to the shadow bitmap and returns the answer.
    function automatic alloc_outcome_t predict_outcome(heap_request_t rq);
        alloc_outcome_t res;
        int need;
        int run;
        int first;
        res.status    = STS_OK;
        res.run_first = '0;
        res.run_len   = '0;
        case (rq.kind)
            KIND_ALLOC:
            begin
                need = (int'(rq.bytes) + ROUND_UP) / BLOCK_BYTES;
                if (need > NUM_BLOCKS)
                    res.status = STS_TOO_LARGE;
                else if (need != 0)
                begin
                    run   = 0;
                    first = -1;
                    for (int i = 0; i < NUM_BLOCKS && first < 0; i++)
                    begin
                        if (used_blocks[i])
                            run = 0;
                        else
                        begin
                            run++;
                            if (run == need)
                                first = i + 1 - need;
                        end
                    end
                    if (first >= 0)
                    begin
                        for (int b = first; b < first + need; b++)
                            used_blocks[b] = 1'b1;
                        res.run_first = first[START_W-1:0];
                    end
                    else
                        res.status = STS_NO_MEMORY;
                    res.run_len = need[COUNT_W-1:0];
                end
            end
            KIND_FREE:
            begin
                if (!rq.valid)
                    res.status = STS_NULL_FREE;
                else if (int'(rq.start) + int'(rq.count) > NUM_BLOCKS)
                    res.status = STS_OOB;
                else
                    for (int b = int'(rq.start); b < int'(rq.start) + int'(rq.count); b++)
                        used_blocks[b] = 1'b0;
            end
            KIND_CLEAR:
                used_blocks = '0;
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic heap_request_t random_request();
        heap_request_t rq;
        rq.kind  = KIND_W'($urandom_range(0, 3));
        rq.bytes = BYTE_W'($urandom_range(0, 65535));
        rq.valid = 1'($urandom_range(0, 1));
        rq.start = START_W'($urandom_range(0, 255));
        rq.count = COUNT_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 16)
                                                         : $urandom_range(0, 511));
        return rq;
    endfunction

    // Sends one transaction and records the expected answer once it is taken.
    task automatic issue_request(heap_request_t rq);
        int gap;
        alloc_outcome_t res;
        live_run_t granted;
        gap = ($urandom_range(0, 99) < req_idle_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        kind        <= rq.kind;
        byte_count  <= rq.bytes;
        block_valid <= rq.valid;
        start_block <= rq.start;
        block_count <= rq.count;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        res = predict_outcome(rq);
        expected_outcomes.push_back(res);
        case (rq.kind)
            KIND_ALLOC:
            begin
                if (res.status == STS_OK && res.run_len != 0)
                begin
                    granted.start = res.run_first;
                    granted.count = res.run_len;
                    live_runs.push_back(granted);
                    n_grants++;
                end
                else if (res.status == STS_NO_MEMORY)
                    n_no_memory++;
                else if (res.status == STS_TOO_LARGE)
                    n_too_large++;
            end
            KIND_FREE:
                if (res.status == STS_OK)
                    n_frees++;
                else
                    n_free_rejects++;
            KIND_CLEAR:
            begin
                live_runs.delete();
                n_clears++;
            end
            default:
                n_unused++;
        endcase
    endtask

    task automatic do_alloc(int bytes);
        heap_request_t rq;
        rq       = random_request();
        rq.kind  = KIND_ALLOC;
        rq.bytes = BYTE_W'(bytes);
        issue_request(rq);
    endtask

    task automatic do_free(logic valid, int start, int count);
        heap_request_t rq;
        rq       = random_request();
        rq.kind  = KIND_FREE;
        rq.valid = valid;
        rq.start = START_W'(start);
        rq.count = COUNT_W'(count);
        issue_request(rq);
    endtask

    task automatic do_other(logic [KIND_W-1:0] k);
        heap_request_t rq;
        rq      = random_request();
        rq.kind = k;
        issue_request(rq);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_outcomes.size() != 0);
    endtask

    task automatic test_directed_cases();
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        do_alloc(0);
        do_alloc(1);
        do_alloc(4);
        do_alloc(5);
        do_alloc(1024);           // partly used map: no room for all blocks
        do_alloc(1025);
        do_alloc(65535);
        do_free(1'b1, 1, 1);
        do_alloc(3);              // first fit lands in the hole at block 1
        do_alloc(8);
        do_free(1'b0, 255, 511);  // null wins over out of bounds
        do_free(1'b1, 255, 2);
        do_free(1'b1, 0, 511);
        do_free(1'b1, 255, 0);
        do_free(1'b1, 255, 1);
        do_other(KIND_UNUSED);
        do_other(KIND_CLEAR);
        do_alloc(1024);
        do_alloc(1);
        do_free(1'b1, 128, 128);
        do_alloc(512);
        do_free(1'b1, 0, 256);
        do_alloc(1021);
        do_other(KIND_CLEAR);
        wait_drained();
    endtask

    // Receiver holds off while cheap transactions pile up behind the output.
    task automatic test_backpressure();
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        rsp_hold_req = RSP_HOLD_LONG;
        repeat (2)
        begin
            do_free(1'b0, $urandom_range(0, 255), $urandom_range(0, 511));
            do_alloc(0);
            do_other(KIND_UNUSED);
            do_alloc($urandom_range(1025, 65535));
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        heap_request_t rq;
        live_run_t victim;
        int r;
        int idx;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ((i / 120) % 3)
                0:
                begin
                    req_idle_pct = 25;
                    rsp_idle_pct = 25;
                end
                1:
                begin
                    req_idle_pct = 0;
                    rsp_idle_pct = 0;
                end
                default:
                begin
                    req_idle_pct = 10;
                    rsp_idle_pct = 60;
                end
            endcase
            rq = random_request();
            r  = $urandom_range(0, 99);
            if (r < 50)
            begin
                rq.kind = KIND_ALLOC;
                r = $urandom_range(0, 99);
                if (r < 70)
                    rq.bytes = BYTE_W'($urandom_range(1, 64));
                else if (r < 90)
                    rq.bytes = BYTE_W'($urandom_range(65, 400));
                else if (r < 97)
                    rq.bytes = BYTE_W'($urandom_range(401, 1024));
                else if (r < 99)
                    rq.bytes = BYTE_W'($urandom_range(1025, 65535));
                else
                    rq.bytes = '0;
            end
            else if (r < 82 && live_runs.size() != 0)
            begin
                idx      = $urandom_range(0, live_runs.size() - 1);
                victim   = live_runs[idx];
                live_runs.delete(idx);
                rq.kind  = KIND_FREE;
                rq.valid = 1'b1;
                rq.start = victim.start;
                rq.count = victim.count;
            end
            else if (r < 94)
            begin
                rq.kind  = KIND_FREE;
                rq.valid = ($urandom_range(0, 9) != 0);
            end
            else if (r < 97)
                rq.kind = KIND_CLEAR;
            else
                rq.kind = KIND_UNUSED;
            issue_request(rq);
            if ($urandom_range(0, 99) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // receiver stall pattern; a long hold is counted here
    always @(posedge clk)
    begin
        if (rsp_hold_req > 0)
        begin
            rsp_hold_left = rsp_hold_req;
            rsp_hold_req  = 0;
        end
        else if (rsp_hold_left == 0 && $urandom_range(0, 99) < rsp_idle_pct)
            rsp_hold_left = pick_gap();
        if (rsp_hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: unexpected transaction: status %0d start %0d length %0d",
                         $time, status, run_start, run_length);
                errors++;
            end
            else
            begin
                oldest = expected_outcomes.pop_front();
                if (status !== oldest.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, oldest.status, status);
                    errors++;
                end
                if (run_start !== oldest.run_first)
                begin
                    $display("%0t: run_start mismatch: expected %0d, actual %0d",
                             $time, oldest.run_first, run_start);
                    errors++;
                end
                if (run_length !== oldest.run_len)
                begin
                    $display("%0t: run_length mismatch: expected %0d, actual %0d",
                             $time, oldest.run_len, run_length);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("tb_first_fit_block_allocator_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_backpressure();
        test_random_traffic();
        repeat (NUM_BLOCKS + 16) @(posedge clk);
        $display("covered: %0d grants, %0d out of memory, %0d too large, %0d frees",
                 n_grants, n_no_memory, n_too_large, n_frees);
        $display("         %0d rejected frees, %0d clears, %0d unused kinds, %0d errors",
                 n_free_rejects, n_clears, n_unused, errors);
        if (errors == 0)
            $display("tb_first_fit_block_allocator_top: PASS");
        else
            $display("tb_first_fit_block_allocator_top: FAIL");
        $finish;
    end

endmodule

[filelist.f]
hdl/ffba_pkg.sv
hdl/ffba_datapath.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator_top.sv
tb/sv/tb_first_fit_block_allocator_top.sv
